// ===== src/dtpq_pkg.sv =====
// shared types and constants of the deferred task priority queue
package dtpq_pkg;

   localparam int NUM_TASKS   = 8;
   localparam int RANK_LEVELS = 16;
   localparam int NUM_KINDS   = 4;

   localparam int IDX_W  = $clog2(NUM_TASKS);
   localparam int LEN_W  = $clog2(NUM_TASKS + 1);
   localparam int OP_W   = 2;
   localparam int TASK_W = 3;
   localparam int KIND_W = 2;
   localparam int RANK_W = 4;
   localparam int STAT_W = 3;
   localparam int CSR_W  = 2;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_IDLE    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_HANDLER  = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_RUNNING = 3'd4;

   typedef enum logic [1:0] {
      SLOT_IDLE    = 2'd0,
      SLOT_QUEUED  = 2'd1,
      SLOT_RUNNING = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RANK,
      S_INSERT,
      S_CMP,
      S_POP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [TASK_W-1:0] task_id;
      logic [KIND_W-1:0] task_kind;
      logic              has_handler;
      logic              requeue;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              popped_valid;
      logic [TASK_W-1:0] popped_task;
      logic [RANK_W-1:0] popped_rank;
      logic              queue_empty;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]  slot;
      logic [RANK_W-1:0] rank;
   } qent_type;

endpackage

// ===== src/deferred_task_priority_queue_unit.sv =====
// deferred task priority queue: circular order memory with sorted insert walk
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_data   (dtpq_pkg::req_type)
//  rsp      out        rsp_valid / rsp_stall  rsp_data   (dtpq_pkg::rsp_type)
//  csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
//  one beat is worked at a time; pop takes the head entry; finish to idle and rejects
//  go to the result directly; enqueue and requeue (after a read of the stored rank)
//  walk from the tail past the queued entries of higher rank up to one of equal or
//  lower rank; one read of the order memory and one compare per entry
//  reset is synchronous; all slots come out idle, the queue empty, ranks 0 1 2 3
//  a finished result sits in the output register; a new beat is taken while it stalls
module deferred_task_priority_queue_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dtpq_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dtpq_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dtpq_pkg::CSR_W-1:0]    csr_index,
   input  logic [dtpq_pkg::RANK_W-1:0]   csr_wdata
);
   import dtpq_pkg::*;

   localparam int SUM_W = LEN_W + 1;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [RANK_W-1:0] new_rank_ff, new_rank_in;
   slot_state_type    slot_status_ff [NUM_TASKS];
   slot_state_type    slot_status_in [NUM_TASKS];
   logic [RANK_W-1:0] rank_reg_ff [NUM_KINDS];

   qent_type          qmem [NUM_TASKS];
   qent_type          q_rd_ff;
   logic              q_rd_en, q_wr_en;
   logic [IDX_W-1:0]  q_rd_addr, q_wr_addr;
   qent_type          q_wr_data;

   logic [RANK_W-1:0] rmem [NUM_TASKS];
   logic [RANK_W-1:0] r_rd_ff;
   logic              r_rd_en, r_wr_en;

   logic [IDX_W-1:0]  id_idx;
   logic              id_exists;
   logic [RANK_W-1:0] rank_sel, rank_sat;
   logic [SUM_W-1:0]  tail_sum;
   logic [IDX_W-1:0]  tail_idx;
   logic [IDX_W-1:0]  pos_prev;
   logic [IDX_W-1:0]  head_next;
   logic [NUM_TASKS-1:0] queued_vec;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign id_idx    = IDX_W'(req_ff.task_id);
   assign id_exists = (32'(req_ff.task_id) < NUM_TASKS);
   assign rank_sel  = rank_reg_ff[req_ff.task_kind];
   assign rank_sat  = (32'(rank_sel) >= RANK_LEVELS) ? RANK_W'(RANK_LEVELS - 1) : rank_sel;
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(len_ff);
   assign tail_idx  = (32'(tail_sum) >= NUM_TASKS) ?
                      IDX_W'(tail_sum - SUM_W'(NUM_TASKS)) : IDX_W'(tail_sum);
   assign pos_prev  = (pos_ff == '0) ? IDX_W'(NUM_TASKS - 1) : pos_ff - 1'b1;
   assign head_next = (32'(head_ff) == NUM_TASKS - 1) ? '0 : head_ff + 1'b1;

   always_comb begin
      for (int i = 0; i < NUM_TASKS; i++) begin
         queued_vec[i] = (slot_status_ff[i] == SLOT_QUEUED);
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      len_in         = len_ff;
      head_in        = head_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      new_rank_in    = new_rank_ff;
      slot_status_in = slot_status_ff;
      req_stall      = 1'b1;
      q_rd_en        = 1'b0;
      q_rd_addr      = head_ff;
      q_wr_en        = 1'b0;
      q_wr_addr      = pos_ff;
      q_wr_data      = '{slot: id_idx, rank: new_rank_ff};
      r_rd_en        = 1'b0;
      r_wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            pos_in   = tail_idx;
            cnt_in   = len_ff;
            state_in = S_DONE;
            case (req_ff.operation)
               OP_ENQUEUE: begin
                  if (!req_ff.has_handler) begin
                     res_in.status = ST_NO_HANDLER;
                  end else if (!id_exists || slot_status_ff[id_idx] != SLOT_IDLE) begin
                     res_in.status = ST_NOT_IDLE;
                  end else begin
                     r_wr_en                = 1'b1;
                     new_rank_in            = rank_sat;
                     slot_status_in[id_idx] = SLOT_QUEUED;
                     state_in               = S_INSERT;
                  end
               end
               OP_POP: begin
                  if (len_ff == '0) begin
                     res_in.status = ST_EMPTY;
                  end else begin
                     q_rd_en  = 1'b1;
                     state_in = S_POP;
                  end
               end
               OP_FINISH: begin
                  if (!id_exists || slot_status_ff[id_idx] != SLOT_RUNNING) begin
                     res_in.status = ST_NOT_RUNNING;
                  end else if (req_ff.requeue) begin
                     r_rd_en                = 1'b1;
                     slot_status_in[id_idx] = SLOT_QUEUED;
                     state_in               = S_RANK;
                  end else begin
                     slot_status_in[id_idx] = SLOT_IDLE;
                  end
               end
               default: begin
                  res_in.status = ST_DONE;
               end
            endcase
         end
         S_RANK: begin
            new_rank_in = r_rd_ff;
            state_in    = S_INSERT;
         end
         S_INSERT: begin
            if (cnt_ff == '0) begin
               q_wr_en  = 1'b1;
               len_in   = len_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               q_rd_en   = 1'b1;
               q_rd_addr = pos_prev;
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            q_wr_en = 1'b1;
            if (q_rd_ff.rank > new_rank_ff) begin
               q_wr_data = q_rd_ff;
               pos_in    = pos_prev;
               cnt_in    = cnt_ff - 1'b1;
               state_in  = S_INSERT;
            end else begin
               len_in   = len_ff + 1'b1;
               state_in = S_DONE;
            end
         end
         S_POP: begin
            res_in.popped_valid            = 1'b1;
            res_in.popped_task             = TASK_W'(q_rd_ff.slot);
            res_in.popped_rank             = q_rd_ff.rank;
            slot_status_in[q_rd_ff.slot]   = SLOT_RUNNING;
            head_in                        = head_next;
            len_in                         = len_ff - 1'b1;
            state_in                       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in             = res_ff;
               rsp_in.queue_empty = (len_ff == '0);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         len_ff         <= '0;
         head_ff        <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            slot_status_ff[i] <= SLOT_IDLE;
         end
         for (int k = 0; k < NUM_KINDS; k++) begin
            rank_reg_ff[k] <= RANK_W'(k);
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         len_ff         <= len_in;
         head_ff        <= head_in;
         slot_status_ff <= slot_status_in;
         if (csr_valid && csr_ready) begin
            rank_reg_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      new_rank_ff <= new_rank_in;
   end

   // queue order memory
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         qmem[q_wr_addr] <= q_wr_data;
      end
      if (q_rd_en) begin
         q_rd_ff <= qmem[q_rd_addr];
      end
   end

   // stored rank per slot
   always_ff @(posedge clock) begin
      if (r_wr_en) begin
         rmem[id_idx] <= rank_sat;
      end
      if (r_rd_en) begin
         r_rd_ff <= rmem[id_idx];
      end
   end

`ifndef ASSERT_OFF
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= NUM_TASKS)
      else $error("queue length beyond slot count");

   a_len_matches_slots : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(queued_vec) == 32'(len_ff))
      else $error("queue length differs from queued slot count");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   a_pop_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.popped_valid |-> rsp_ff.status == ST_DONE)
      else $error("popped result with error status");

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_ff.queue_empty == (len_ff == '0))
      else $error("empty flag disagrees with queue length");
`endif

endmodule

// ===== tb/dtpq_checker.sv =====
// response checker of the deferred task priority queue: predicts each rsp beat and compares it
module dtpq_checker
   import dtpq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [RANK_W-1:0] csr_wdata,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [RANK_W-1:0] kind_rank [NUM_KINDS];
   slot_state_type    task_state [NUM_TASKS];
   logic [RANK_W-1:0] task_rank [NUM_TASKS];
   logic [TASK_W-1:0] run_order [$];
   rsp_type           awaited [$];
   int                errors;
   int                rsp_beats;

   task automatic flag(input string msg);
      $display("ERROR t=%0t rsp beat %0d: %s", $time, rsp_beats, msg);
      errors++;
   endtask

   // stable sorted insert: behind every entry of equal or lower rank
   function automatic void file_in_order(input logic [TASK_W-1:0] slot);
      int pos;
      pos = 0;
      while (pos < run_order.size() && task_rank[run_order[pos]] <= task_rank[slot])
         pos++;
      run_order.insert(pos, slot);
   endfunction

   function automatic rsp_type predict_outcome(input req_type beat);
      rsp_type           outcome;
      logic [TASK_W-1:0] head;
      int                level;
      outcome = '0;
      outcome.status = ST_DONE;
      case (beat.operation)
         OP_ENQUEUE: begin
            if (!beat.has_handler) begin
               outcome.status = ST_NO_HANDLER;
            end else if (task_state[beat.task_id] != SLOT_IDLE) begin
               outcome.status = ST_NOT_IDLE;
            end else begin
               level = int'(kind_rank[beat.task_kind]);
               if (level > RANK_LEVELS - 1)
                  level = RANK_LEVELS - 1;
               task_rank[beat.task_id] = RANK_W'(level);
               file_in_order(beat.task_id);
               task_state[beat.task_id] = SLOT_QUEUED;
            end
         end
         OP_POP: begin
            if (run_order.size() == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               head = run_order.pop_front();
               task_state[head] = SLOT_RUNNING;
               outcome.popped_valid = 1'b1;
               outcome.popped_task  = head;
               outcome.popped_rank  = task_rank[head];
            end
         end
         OP_FINISH: begin
            if (task_state[beat.task_id] != SLOT_RUNNING) begin
               outcome.status = ST_NOT_RUNNING;
            end else if (beat.requeue) begin
               task_state[beat.task_id] = SLOT_QUEUED;
               file_in_order(beat.task_id);
            end else begin
               task_state[beat.task_id] = SLOT_IDLE;
            end
         end
         default: begin
         end
      endcase
      outcome.queue_empty = (run_order.size() == 0);
      return outcome;
   endfunction

   task automatic compare_beat(input rsp_type got);
      rsp_type want;
      if (awaited.size() == 0) begin
         flag($sformatf("response with nothing awaited, status %0d task %0d",
                        got.status, got.popped_task));
      end else begin
         want = awaited.pop_front();
         if (got.status !== want.status)
            flag($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.popped_valid !== want.popped_valid)
            flag($sformatf("popped_valid %0b, expected %0b", got.popped_valid,
                           want.popped_valid));
         if (got.popped_task !== want.popped_task)
            flag($sformatf("popped_task %0d, expected %0d", got.popped_task,
                           want.popped_task));
         if (got.popped_rank !== want.popped_rank)
            flag($sformatf("popped_rank %0d, expected %0d", got.popped_rank,
                           want.popped_rank));
         if (got.queue_empty !== want.queue_empty)
            flag($sformatf("queue_empty %0b, expected %0b", got.queue_empty,
                           want.queue_empty));
      end
      rsp_beats++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KINDS; k++)
            kind_rank[k] = RANK_W'(k);
         for (int s = 0; s < NUM_TASKS; s++) begin
            task_state[s] = SLOT_IDLE;
            task_rank[s]  = '0;
         end
         run_order.delete();
         awaited.delete();
         errors    = 0;
         rsp_beats = 0;
      end else begin
         if (csr_valid && csr_ready)
            kind_rank[csr_index] = csr_wdata;
         if (req_valid && !req_stall)
            awaited.push_back(predict_outcome(req_data));
         if (rsp_valid && !rsp_stall)
            compare_beat(rsp_data);
      end
      pending    <= awaited.size();
      fail_count <= errors;
   end

endmodule

// ===== tb/deferred_task_priority_queue_unit_tb.sv =====
// testbench top of the deferred task priority queue: clock, reset, stimulus, stalls and verdict
module deferred_task_priority_queue_unit_tb;
   import dtpq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0]  OP_UNUSED        = 2'd3;
   localparam logic [CSR_W-1:0] CSR_RANK_TIMER   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_RANK_UART_RX = 2'd1;
   localparam logic [CSR_W-1:0] CSR_RANK_UART_TX = 2'd2;
   localparam logic [CSR_W-1:0] CSR_RANK_OTHER   = 2'd3;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int LONG_HOLD       = 150;
   localparam int DRAIN_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT  = 3000;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index;
   logic [RANK_W-1:0] csr_wdata;
   int                fail_count;
   int                pending;
   bit                calm = 1'b0;
   bit                long_hold_due = 1'b0;

   always #5 clock = ~clock;

   deferred_task_priority_queue_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dtpq_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic send_beat(input req_type beat);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic issue(input logic [OP_W-1:0] op, input int id, input int kind,
                        input bit handler, input bit again);
      req_type beat;
      beat.operation   = op;
      beat.task_id     = TASK_W'(id);
      beat.task_kind   = KIND_W'(kind);
      beat.has_handler = handler;
      beat.requeue     = again;
      send_beat(beat);
   endtask

   // fill phases favor enqueue, the others favor pop so that slots pile up running
   function automatic req_type random_item(input bit fill);
      req_type beat;
      int      pick;
      beat.task_id     = TASK_W'($urandom_range(0, NUM_TASKS - 1));
      beat.task_kind   = KIND_W'($urandom_range(0, NUM_KINDS - 1));
      beat.has_handler = ($urandom_range(0, 9) != 0);
      beat.requeue     = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < (fill ? 55 : 30))
         beat.operation = OP_ENQUEUE;
      else if (pick < (fill ? 75 : 65))
         beat.operation = OP_POP;
      else if (pick < 96)
         beat.operation = OP_FINISH;
      else
         beat.operation = OP_UNUSED;
      return beat;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic put_csr(input logic [CSR_W-1:0] index, input logic [RANK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_ranks(input logic [RANK_W-1:0] r_timer, input logic [RANK_W-1:0] r_rx,
                             input logic [RANK_W-1:0] r_tx, input logic [RANK_W-1:0] r_other);
      put_csr(CSR_RANK_TIMER, r_timer);
      put_csr(CSR_RANK_UART_RX, r_rx);
      put_csr(CSR_RANK_UART_TX, r_tx);
      put_csr(CSR_RANK_OTHER, r_other);
      csr_valid <= 1'b0;
   endtask

   initial begin : rsp_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("deferred_task_priority_queue_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset ranks 0 1 2 3
      issue(OP_POP, 0, 0, 1'b1, 1'b0);
      issue(OP_FINISH, 0, 0, 1'b1, 1'b0);
      issue(OP_UNUSED, 7, 3, 1'b1, 1'b1);
      issue(OP_ENQUEUE, 7, 3, 1'b0, 1'b0);
      issue(OP_ENQUEUE, 7, 3, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 7, 3, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 0, 0, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 5, 3, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 2, 1, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 3, 2, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 1, 0, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 4, 2, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 6, 1, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 5, 0, 1'b0, 1'b1);
      repeat (3) issue(OP_POP, 0, 0, 1'b1, 1'b0);
      issue(OP_ENQUEUE, 1, 0, 1'b1, 1'b0);
      issue(OP_FINISH, 0, 0, 1'b1, 1'b1);
      issue(OP_FINISH, 1, 0, 1'b1, 1'b0);
      issue(OP_FINISH, 1, 0, 1'b1, 1'b0);
      issue(OP_FINISH, 7, 0, 1'b1, 1'b1);
      repeat (3) issue(OP_POP, 0, 0, 1'b1, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: load_ranks(4'd0, 4'd0, 4'd0, 4'd0);
            1: load_ranks(4'd15, 4'd15, 4'd15, 4'd15);
            2: load_ranks(4'd15, 4'd10, 4'd5, 4'd0);
            3: load_ranks(4'd0, 4'd15, 4'd0, 4'd15);
            default: load_ranks(RANK_W'($urandom_range(0, 15)),
                                RANK_W'($urandom_range(0, 15)),
                                RANK_W'($urandom_range(0, 15)),
                                RANK_W'($urandom_range(0, 15)));
         endcase
         calm = (ph == PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 1 && n == 50)
               long_hold_due = 1'b1;
            if (ph == 3 && n == 100)
               wait_drained();
            send_beat(random_item(ph % 2 == 0));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("deferred_task_priority_queue_unit verification clean");
      else
         $display("deferred_task_priority_queue_unit verification failed");
      $finish;
   end

endmodule
